@@ hw/rtl/dmrc_pkg.sv @@
// shared constants, types and helpers of the direct mapped read cache
package dmrc_pkg;

    localparam int NUM_LINES  = 256;
    localparam int LINE_BYTES = 64;
    localparam int ADDR_BITS  = 32;

    localparam int IDX_W      = $clog2(NUM_LINES);
    localparam int OFF_W      = $clog2(LINE_BYTES);
    localparam int WORDS      = LINE_BYTES / 8;
    localparam int WORD_W     = $clog2(WORDS);
    localparam int HALF_W     = WORD_W - 1;
    localparam int BANK_DEPTH = NUM_LINES * (WORDS / 2);
    localparam int BANK_AW    = IDX_W + HALF_W;
    localparam int TAG_W      = ADDR_BITS - OFF_W - IDX_W;

    localparam logic [31:0]       ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [31:0]       LINE_MASK = 32'(LINE_BYTES - 1);
    localparam logic [OFF_W-1:0]  OFF_MAX   = OFF_W'(LINE_BYTES - 8);
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(WORDS - 1);

    // result codes
    localparam logic [2:0] ST_HIT        = 3'd0;
    localparam logic [2:0] ST_FILLED     = 3'd1;
    localparam logic [2:0] ST_FILL_REQ   = 3'd2;
    localparam logic [2:0] ST_OFFSET_ERR = 3'd3;
    localparam logic [2:0] ST_BUSY       = 3'd4;

    // item held between the lookup stage and the decision stage
    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [31:0] addr;
        logic [63:0] fill_word;
    } t_item;

    // memory writes issued by the decision stage
    typedef struct packed {
        logic               tag_we;
        logic [IDX_W-1:0]   tag_idx;
        logic [TAG_W-1:0]   tag_data;
        logic               word_we;
        logic               word_odd;
        logic [BANK_AW-1:0] word_idx;
        logic [63:0]        word_data;
    } t_wr;

    // one result beat
    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic [63:0] read_data;
        logic [31:0] block_address;
    } t_res;

    function automatic logic [IDX_W-1:0] line_of(logic [31:0] a);
        return IDX_W'(a >> OFF_W);
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(logic [31:0] a);
        return TAG_W'(a >> (OFF_W + IDX_W));
    endfunction

    function automatic logic [31:0] aligned_of(logic [31:0] a);
        return a & ~LINE_MASK;
    endfunction

    // eight bytes starting at byte sh of lo, continuing into hi
    function automatic logic [63:0] gather(logic [63:0] lo, logic [63:0] hi, logic [2:0] sh);
        logic [127:0] both;
        both = {hi, lo} >> {sh, 3'b000};
        return both[63:0];
    endfunction

endpackage

@@ hw/rtl/dmrc_ram.sv @@
// generic one-write one-read memory, registered read, new data on same-address write
module dmrc_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/dmrc_ctrl.sv @@
// decision stage: hit check, fill sequencing, line state and result register
module dmrc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dmrc_pkg::t_item       i_s1,
    input  logic [dmrc_pkg::TAG_W-1:0] i_tag_q,
    input  logic [63:0]           i_even_q,
    input  logic [63:0]           i_odd_q,
    output logic [31:0]           o_pend_addr,
    output dmrc_pkg::t_wr         o_wr,
    output dmrc_pkg::t_res        o_res
);

    logic [dmrc_pkg::NUM_LINES-1:0] r_line_valid, n_line_valid;
    logic                           r_pending, n_pending;
    logic [31:0]                    r_pend_addr, n_pend_addr;
    logic [dmrc_pkg::WORD_W-1:0]    r_beat, n_beat;
    dmrc_pkg::t_res                 r_res, n_res;

    logic [31:0]                    g_addr;
    logic [dmrc_pkg::OFF_W-1:0]     g_off;
    logic [dmrc_pkg::WORD_W-1:0]    g_w0, g_w1;
    logic [63:0]                    word0, word1, gathered;
    logic [dmrc_pkg::IDX_W-1:0]     rd_line, pend_line;
    logic [dmrc_pkg::OFF_W-1:0]     rd_off;

    // words for the gather, taking the beat being written now straight from the input
    always_comb begin
        g_addr = i_s1.kind ? r_pend_addr : i_s1.addr;
        g_off  = g_addr[dmrc_pkg::OFF_W-1:0];
        g_w0   = g_off[dmrc_pkg::OFF_W-1:3];
        g_w1   = g_w0 + 1'b1;
        word0  = g_w0[0] ? i_odd_q : i_even_q;
        word1  = g_w0[0] ? i_even_q : i_odd_q;
        if (i_s1.kind && (g_w0 == dmrc_pkg::LAST_WORD)) begin
            word0 = i_s1.fill_word;
        end
        if (i_s1.kind && (g_w1 == dmrc_pkg::LAST_WORD)) begin
            word1 = i_s1.fill_word;
        end
        gathered = dmrc_pkg::gather(word0, word1, g_off[2:0]);
    end

    always_comb begin
        rd_line      = dmrc_pkg::line_of(i_s1.addr);
        rd_off       = i_s1.addr[dmrc_pkg::OFF_W-1:0];
        pend_line    = dmrc_pkg::line_of(r_pend_addr);
        n_line_valid = r_line_valid;
        n_pending    = r_pending;
        n_pend_addr  = r_pend_addr;
        n_beat       = r_beat;
        n_res        = '0;
        o_wr         = '0;
        if (i_s1.valid) begin
            if (i_s1.kind) begin
                if (r_pending) begin
                    o_wr.word_we   = 1'b1;
                    o_wr.word_odd  = r_beat[0];
                    o_wr.word_idx  = {pend_line, r_beat[dmrc_pkg::WORD_W-1:1]};
                    o_wr.word_data = i_s1.fill_word;
                    if (r_beat == dmrc_pkg::LAST_WORD) begin
                        n_beat                  = '0;
                        n_pending               = 1'b0;
                        n_line_valid[pend_line] = 1'b1;
                        o_wr.tag_we             = 1'b1;
                        o_wr.tag_idx            = pend_line;
                        o_wr.tag_data           = dmrc_pkg::tag_of(r_pend_addr);
                        n_res.valid             = 1'b1;
                        n_res.status            = dmrc_pkg::ST_FILLED;
                        n_res.read_data         = gathered;
                        n_res.block_address     = dmrc_pkg::aligned_of(r_pend_addr);
                    end else begin
                        n_beat = r_beat + 1'b1;
                    end
                end
            end else begin
                n_res.valid         = 1'b1;
                n_res.block_address = dmrc_pkg::aligned_of(i_s1.addr);
                if (r_pending) begin
                    n_res.status = dmrc_pkg::ST_BUSY;
                end else if (rd_off > dmrc_pkg::OFF_MAX) begin
                    n_res.status = dmrc_pkg::ST_OFFSET_ERR;
                end else if (r_line_valid[rd_line] &&
                             (i_tag_q == dmrc_pkg::tag_of(i_s1.addr))) begin
                    n_res.status    = dmrc_pkg::ST_HIT;
                    n_res.read_data = gathered;
                end else begin
                    n_line_valid[rd_line] = 1'b0;
                    n_pending             = 1'b1;
                    n_pend_addr           = i_s1.addr;
                    n_beat                = '0;
                    n_res.status          = dmrc_pkg::ST_FILL_REQ;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_valid <= '0;
            r_pending    <= 1'b0;
            r_pend_addr  <= '0;
            r_beat       <= '0;
            r_res.valid  <= 1'b0;
        end else begin
            r_line_valid <= n_line_valid;
            r_pending    <= n_pending;
            r_pend_addr  <= n_pend_addr;
            r_beat       <= n_beat;
            r_res        <= n_res;
        end
    end

    assign o_pend_addr = r_pend_addr;
    assign o_res       = r_res;

endmodule

@@ hw/rtl/direct_mapped_read_cache_core.sv @@
// top level of the direct mapped read cache: lookup stage, tag and data memories, decision stage
// a result beat passes the lookup stage register and the result register, and is taken at the next edge
// throughput: one request or fill beat per cycle, busy never rises
// the fill word that completes a line gives its data beat after the lookup stage and result registers
// reset: synchronous active low, clears line valid bits, fill state, the lookup stage valid bit and the result strobe
// the receiver cannot stall: every result beat is taken in the cycle it is shown
module direct_mapped_read_cache_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [31:0] i_address,
    input  logic [63:0] i_fill_word,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [63:0] o_read_data,
    output logic [31:0] o_block_address
);

    // lookup stage register and its next value
    dmrc_pkg::t_item r_s1, n_s1;

    logic [31:0]                    s0_addr;
    logic [31:0]                    rd_addr;
    logic [31:0]                    pend_addr;
    logic [dmrc_pkg::IDX_W-1:0]     rd_line;
    logic [dmrc_pkg::WORD_W-1:0]    rd_w0;
    logic [dmrc_pkg::WORD_W-1:0]    rd_w0_inc;
    logic [dmrc_pkg::BANK_AW-1:0]   even_ra, odd_ra;
    logic [dmrc_pkg::TAG_W-1:0]     tag_q;
    logic [63:0]                    even_q, odd_q;
    dmrc_pkg::t_wr                  wr;
    dmrc_pkg::t_res                 res;

    // every cycle takes a beat; there is nothing to hold off
    assign busy = 1'b0;

    // address is trimmed to the cache's address space before anything else
    assign s0_addr = i_address & dmrc_pkg::ADDR_MASK;

    // fill beats read the pending line so the last beat can return its eight bytes;
    // reads look up the line of their own address
    assign rd_addr   = i_kind ? pend_addr : s0_addr;
    assign rd_line   = dmrc_pkg::line_of(rd_addr);
    assign rd_w0     = rd_addr[dmrc_pkg::OFF_W-1:3];
    assign rd_w0_inc = rd_w0 + 1'b1;

    // words are split into even and odd banks so the two words a read spans
    // always sit in different banks; the odd bank holds word w0 or w0+1,
    // the even bank the other one
    assign odd_ra  = {rd_line, rd_w0[dmrc_pkg::WORD_W-1:1]};
    assign even_ra = {rd_line, rd_w0_inc[dmrc_pkg::WORD_W-1:1]};

    always_comb begin
        n_s1           = r_s1;
        n_s1.valid     = start && !busy;
        n_s1.kind      = i_kind;
        n_s1.addr      = s0_addr;
        n_s1.fill_word = i_fill_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    // tag store: written when a fill completes, read in the lookup stage
    dmrc_ram #(
        .DEPTH (dmrc_pkg::NUM_LINES),
        .WIDTH (dmrc_pkg::TAG_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (wr.tag_we),
        .i_waddr (wr.tag_idx),
        .i_wdata (wr.tag_data),
        .i_raddr (rd_line),
        .o_rdata (tag_q)
    );

    // even data words of every line
    dmrc_ram #(
        .DEPTH (dmrc_pkg::BANK_DEPTH),
        .WIDTH (64)
    ) u_even_ram (
        .i_clk   (i_clk),
        .i_we    (wr.word_we && !wr.word_odd),
        .i_waddr (wr.word_idx),
        .i_wdata (wr.word_data),
        .i_raddr (even_ra),
        .o_rdata (even_q)
    );

    // odd data words of every line
    dmrc_ram #(
        .DEPTH (dmrc_pkg::BANK_DEPTH),
        .WIDTH (64)
    ) u_odd_ram (
        .i_clk   (i_clk),
        .i_we    (wr.word_we && wr.word_odd),
        .i_waddr (wr.word_idx),
        .i_wdata (wr.word_data),
        .i_raddr (odd_ra),
        .o_rdata (odd_q)
    );

    // decision stage; its writes land in the same cycle the next beat reads,
    // and the memories pass the new data through on a matching address
    dmrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1        (r_s1),
        .i_tag_q     (tag_q),
        .i_even_q    (even_q),
        .i_odd_q     (odd_q),
        .o_pend_addr (pend_addr),
        .o_wr        (wr),
        .o_res       (res)
    );

    assign o_valid         = res.valid;
    assign o_status        = res.status;
    assign o_read_data     = res.read_data;
    assign o_block_address = res.block_address;

    // a result beat always traces back to an accepted beat that passed the lookup stage and result registers
    a_res_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 2))
        else $error("result beat without an accepted beat two cycles earlier");

    // only hits and completed fills carry data
    a_no_data_on_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == dmrc_pkg::ST_FILL_REQ ||
                     o_status == dmrc_pkg::ST_OFFSET_ERR ||
                     o_status == dmrc_pkg::ST_BUSY)) |-> (o_read_data == 64'd0))
        else $error("data on a result that carries none");

    // right after a fill request the line is still pending: no hit and no second request
    a_pending_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == dmrc_pkg::ST_FILL_REQ) |=>
            !(o_valid && (o_status == dmrc_pkg::ST_HIT ||
                          o_status == dmrc_pkg::ST_FILL_REQ)))
        else $error("lookup served while a fill is pending");

endmodule

@@ test/testbench.sv @@
// self-checking testbench of the direct mapped read cache core with its own line and fill model
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // cache geometry taken from the shared package
    localparam int NUM_LINES  = dmrc_pkg::NUM_LINES;
    localparam int LINE_BYTES = dmrc_pkg::LINE_BYTES;
    localparam int WORDS      = dmrc_pkg::WORDS;
    localparam int IDX_W      = dmrc_pkg::IDX_W;
    localparam int OFF_W      = dmrc_pkg::OFF_W;
    localparam int TAG_W      = dmrc_pkg::TAG_W;

    // beat kinds on i_kind
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_FILL = 1'b1;

    // cycles with no accepted beat and no result beat before the run is called dead
    localparam int WATCHDOG_LIMIT = 1000;
    // cycles to let pass once nothing is owed any more
    localparam int SETTLE_CYCLES  = 4;

    // one result beat as the cache should present it
    typedef struct {
        logic [2:0]  status;
        logic [63:0] data;
        logic [31:0] blk;
    } t_cache_beat;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic        busy;
    logic        i_kind          = KIND_READ;
    logic [31:0] i_address       = '0;
    logic [63:0] i_fill_word     = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [63:0] o_read_data;
    logic [31:0] o_block_address;

    // mirror of the cache contents and of the line fill in flight
    logic              mirror_valid [NUM_LINES];
    logic [TAG_W-1:0]  mirror_tag   [NUM_LINES];
    logic [63:0]       mirror_words [NUM_LINES][WORDS];
    logic              fill_open;
    logic [31:0]       fill_addr;
    int                fill_word_no;

    // result beats owed by the cache, oldest first
    t_cache_beat owed_beats[$];

    // address pools that keep lines colliding and hitting
    logic [TAG_W-1:0] tag_pool [4];
    logic [IDX_W-1:0] idx_pool [6];

    int idle_pct;
    int fail_count;
    int idle_cycles;
    int beats_sent;
    int stray_fills;
    int seen_status [5];

    direct_mapped_read_cache_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_address       (i_address),
        .i_fill_word     (i_fill_word),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_read_data     (o_read_data),
        .o_block_address (o_block_address)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // eight little-endian bytes of a mirrored line starting at a byte offset
    function automatic logic [63:0] line_bytes(int idx, int off);
        logic [WORDS*64-1:0] flat;
        for (int w = 0; w < WORDS; w++) begin
            flat[w*64 +: 64] = mirror_words[idx][w];
        end
        return flat[off*8 +: 64];
    endfunction

    // advance the mirror by one accepted beat and queue the result it owes
    // returns 0 only for a fill beat that the cache drops
    function automatic bit mirror_access(logic kind, logic [31:0] addr, logic [63:0] word);
        t_cache_beat      beat;
        logic [31:0]      a;
        logic [IDX_W-1:0] idx;
        logic [TAG_W-1:0] tg;
        logic [OFF_W-1:0] off;
        a = addr & dmrc_pkg::ADDR_MASK;
        if (kind == KIND_FILL) begin
            // fill beat with no miss outstanding is dropped
            if (!fill_open) return 1'b0;
            idx = fill_addr[OFF_W +: IDX_W];
            mirror_words[idx][fill_word_no] = word;
            if (fill_word_no < WORDS - 1) begin
                fill_word_no++;
                return 1'b1;
            end
            // last word closes the line and answers the original read
            fill_word_no      = 0;
            fill_open         = 1'b0;
            mirror_valid[idx] = 1'b1;
            mirror_tag[idx]   = fill_addr[OFF_W+IDX_W +: TAG_W];
            beat.status = dmrc_pkg::ST_FILLED;
            beat.data   = line_bytes(idx, fill_addr[OFF_W-1:0]);
            beat.blk    = fill_addr & ~dmrc_pkg::LINE_MASK;
            owed_beats  = {owed_beats, beat};
            return 1'b1;
        end
        idx = a[OFF_W +: IDX_W];
        tg  = a[OFF_W+IDX_W +: TAG_W];
        off = a[OFF_W-1:0];
        beat.data = '0;
        beat.blk  = a & ~dmrc_pkg::LINE_MASK;
        if (fill_open) begin
            beat.status = dmrc_pkg::ST_BUSY;
        end else if (off > dmrc_pkg::OFF_MAX) begin
            // read would run past the end of the line
            beat.status = dmrc_pkg::ST_OFFSET_ERR;
        end else if (mirror_valid[idx] && mirror_tag[idx] == tg) begin
            beat.status = dmrc_pkg::ST_HIT;
            beat.data   = line_bytes(idx, off);
        end else begin
            // miss drops the old line at once and opens the fill
            mirror_valid[idx] = 1'b0;
            fill_open         = 1'b1;
            fill_addr         = a;
            fill_word_no      = 0;
            beat.status       = dmrc_pkg::ST_FILL_REQ;
        end
        owed_beats = {owed_beats, beat};
        return 1'b1;
    endfunction

    // offer one beat after a random idle gap and hold it until the cache takes it
    // start stays high when the next beat follows with no gap
    task automatic send_beat(input logic kind, input logic [31:0] addr,
                             input logic [63:0] word, output bit counted);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_kind      <= kind;
        i_address   <= addr;
        i_fill_word <= word;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        counted = mirror_access(kind, addr, word);
        beats_sent++;
        if (!counted) stray_fills++;
    endtask

    // sender goes quiet until every owed beat has come back
    task automatic test_drain_pause();
        start <= 1'b0;
        @(posedge i_clk);
        while (owed_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // cold miss on line zero, fill with extreme words, then hit the last legal offset
    task automatic test_cold_miss_fill_hit();
        bit          counted;
        logic [63:0] words [WORDS];
        words = '{64'h0, '1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                  64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                  64'h8000_0000_0000_0001, {$urandom, $urandom}};
        send_beat(KIND_READ, 32'h0000_0000, '1, counted);
        foreach (words[w]) send_beat(KIND_FILL, $urandom, words[w], counted);
        send_beat(KIND_READ, 32'h0000_0038, '0, counted);
    endtask

    // offsets past the last full word of a line, valid line and cold line
    task automatic test_offset_errors();
        bit counted;
        send_beat(KIND_READ, 32'h0000_0039, {$urandom, $urandom}, counted);
        send_beat(KIND_READ, 32'h0000_003F, {$urandom, $urandom}, counted);
        send_beat(KIND_READ, 32'hFFFF_FFFF, {$urandom, $urandom}, counted);
    endtask

    // dropped fill beat, miss at the top of the address space, read while filling
    task automatic test_busy_and_stray_fill();
        bit counted;
        send_beat(KIND_FILL, '1, '1, counted);
        send_beat(KIND_READ, 32'hFFFF_FFC7, '0, counted);
        send_beat(KIND_READ, 32'h0000_0000, '0, counted);
        repeat (WORDS) send_beat(KIND_FILL, $urandom, {$urandom, $urandom}, counted);
        send_beat(KIND_READ, 32'hFFFF_FFC7, '1, counted);
    endtask

    function automatic logic [31:0] pick_address();
        logic [TAG_W-1:0] tg;
        logic [IDX_W-1:0] idx;
        logic [OFF_W-1:0] off;
        if ($urandom_range(19) == 0) return $urandom;
        case ($urandom_range(3))
            0:       tg = '0;
            1:       tg = '1;
            default: tg = tag_pool[$urandom_range(3)];
        endcase
        idx = ($urandom_range(3) == 0) ? IDX_W'($urandom) : idx_pool[$urandom_range(5)];
        off = ($urandom_range(4) == 0) ? OFF_W'($urandom) : OFF_W'($urandom_range(LINE_BYTES - 8));
        return {tg, idx, off};
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mostly complete miss and fill sequences, with reads cutting into fills
    // and fill beats arriving with nothing to fill
    task automatic test_random_traffic(input int pct, input int n_beats);
        bit counted;
        int done;
        done     = 0;
        idle_pct = pct;
        while (done < n_beats) begin
            if (fill_open) begin
                if ($urandom_range(9) == 0)
                    send_beat(KIND_READ, pick_address(), pick_word(), counted);
                else
                    send_beat(KIND_FILL, $urandom, pick_word(), counted);
            end else begin
                if ($urandom_range(9) == 0)
                    send_beat(KIND_FILL, $urandom, pick_word(), counted);
                else
                    send_beat(KIND_READ, pick_address(), pick_word(), counted);
            end
            if (counted) done++;
        end
    endtask

    // compare each result beat with the oldest owed one
    always @(posedge i_clk) begin
        t_cache_beat want;
        if (i_rst_n && o_valid) begin
            if (owed_beats.size() == 0) begin
                $error("result beat with nothing owed: status %0d data %h block %h",
                       o_status, o_read_data, o_block_address);
                fail_count++;
            end else begin
                want = owed_beats.pop_front();
                if (o_status < 5) seen_status[o_status]++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_read_data !== want.data) begin
                    $error("read_data: expected %h, got %h", want.data, o_read_data);
                    fail_count++;
                end
                if (o_block_address !== want.blk) begin
                    $error("block_address: expected %h, got %h", want.blk, o_block_address);
                    fail_count++;
                end
            end
        end
    end

    // dead-run guard: any taken request or shown result restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results owed",
                     idle_cycles, owed_beats.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        fail_count   = 0;
        idle_cycles  = 0;
        beats_sent   = 0;
        stray_fills  = 0;
        idle_pct     = 0;
        fill_open    = 1'b0;
        fill_addr    = '0;
        fill_word_no = 0;
        foreach (mirror_valid[i]) mirror_valid[i] = 1'b0;
        foreach (seen_status[i]) seen_status[i] = 0;
        tag_pool = '{TAG_W'($urandom), TAG_W'($urandom), TAG_W'($urandom), TAG_W'(1)};
        idx_pool = '{'0, '1, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                     IDX_W'(1)};

        // reset held low at the start, then released
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_cold_miss_fill_hit();
        test_offset_errors();
        test_busy_and_stray_fill();
        test_drain_pause();

        // idle phases: none, heavy, light, none again
        test_random_traffic(0, 250);
        test_drain_pause();
        test_random_traffic(59, 250);
        test_drain_pause();
        test_random_traffic(16, 250);
        test_drain_pause();
        test_random_traffic(0, 250);
        test_drain_pause();

        $display("sent %0d beats (%0d fill beats with nothing to fill) over four idle phases",
                 beats_sent, stray_fills);
        $display("results: %0d hits, %0d fills done, %0d misses, %0d offset errors, %0d busy",
                 seen_status[dmrc_pkg::ST_HIT], seen_status[dmrc_pkg::ST_FILLED],
                 seen_status[dmrc_pkg::ST_FILL_REQ], seen_status[dmrc_pkg::ST_OFFSET_ERR],
                 seen_status[dmrc_pkg::ST_BUSY]);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/dmrc_pkg.sv
hw/rtl/dmrc_ram.sv
hw/rtl/dmrc_ctrl.sv
hw/rtl/direct_mapped_read_cache_core.sv
test/testbench.sv
